@@ hdl/led_strip_effect_pixel_color_unit_assert.svh @@
// assertion macros for the led strip pixel colour unit
`ifndef LED_STRIP_EFFECT_PIXEL_COLOR_UNIT_ASSERT_SVH
`define LED_STRIP_EFFECT_PIXEL_COLOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define LSEPC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define LSEPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define LSEPC_ASSERT_IMP(name, ante, cons)
`define LSEPC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ hdl/lsepc_pkg.sv @@
// shared types, codes and colour and arithmetic functions for the led strip pixel colour unit
package lsepc_pkg;

  typedef enum logic [2:0] {
    EFF_RAINBOW  = 3'd0,
    EFF_CYCLE    = 3'd1,
    EFF_CHASE    = 3'd2,
    EFF_CHASE_RB = 3'd3,
    EFF_WIPE     = 3'd4,
    EFF_BLINK    = 3'd5,
    EFF_GLYPH    = 3'd6
  } effect_t;

  localparam logic [1:0] REG_EFFECT      = 2'd0;
  localparam logic [1:0] REG_PIXEL_COUNT = 2'd1;
  localparam logic [1:0] REG_FORE_COLOR  = 2'd2;
  localparam logic [1:0] REG_BACK_COLOR  = 2'd3;

  localparam logic [4:0] PIXEL_COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    SRC_FLAT  = 2'd0,
    SRC_WHEEL = 2'd1,
    SRC_CYCLE = 2'd2
  } color_src_t;

  typedef struct packed {
    logic        valid;
    logic        wr;
    color_src_t  src;
    logic [7:0]  pos;
    logic [23:0] flat;
  } stage_word_t;

  function automatic logic [1:0] mod3(input logic [3:0] v);
    case (v)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: mod3 = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13: mod3 = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11, 4'd14: mod3 = 2'd2;
      default: mod3 = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] mod255(input logic [11:0] v);
    logic [8:0] s;
    s = {5'd0, v[11:8]} + {1'b0, v[7:0]};
    mod255 = (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
  endfunction

  // three segment ramp, packed green, red, blue
  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] w;
    logic [7:0] wa;
    logic [9:0] t;
    logic [7:0] w3;
    w = ~pos;
    if (w < 8'd85) begin
      wa = w;
    end else if (w < 8'd170) begin
      wa = w - 8'd85;
    end else begin
      wa = w - 8'd170;
    end
    t  = {2'b00, wa} + {1'b0, wa, 1'b0};
    w3 = t[7:0];
    if (w < 8'd85) begin
      wheel = {8'd0, 8'd255 - w3, w3};
    end else if (w < 8'd170) begin
      wheel = {w3, 8'd0, 8'd255 - w3};
    end else begin
      wheel = {8'd255 - w3, w3, 8'd0};
    end
  endfunction

endpackage

@@ hdl/lsepc_div.sv @@
// two stage restoring divider for the rainbow cycle position p*256/n
module lsepc_div (
  input  logic       clk,
  input  logic [3:0] p,
  input  logic [4:0] n,
  output logic [7:0] quot
);

  logic [4:0] rem1;
  logic [3:0] qhi;
  logic [4:0] n1;

  logic [5:0] ra;
  logic [5:0] ta;
  logic [3:0] qa;
  logic [5:0] rb;
  logic [5:0] tb;
  logic [3:0] qb;

  // upper four quotient bits
  always_comb begin
    ra = {2'b00, p};
    qa = 4'd0;
    for (int i = 0; i < 4; i++) begin
      ta = {ra[4:0], 1'b0};
      if (ta >= {1'b0, n}) begin
        ra = ta - {1'b0, n};
        qa = {qa[2:0], 1'b1};
      end else begin
        ra = ta;
        qa = {qa[2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem1 <= ra[4:0];
    qhi  <= qa;
    n1   <= n;
  end

  // lower four quotient bits
  always_comb begin
    rb = {1'b0, rem1};
    qb = 4'd0;
    for (int i = 0; i < 4; i++) begin
      tb = {rb[4:0], 1'b0};
      if (tb >= {1'b0, n1}) begin
        rb = tb - {1'b0, n1};
        qb = {qb[2:0], 1'b1};
      end else begin
        rb = tb;
        qb = {qb[2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= {qhi, qb};
  end

endmodule

@@ hdl/lsepc_color.sv @@
// last stage: wheel colour lookup, final colour select and output register
module lsepc_color (
  input  logic                      clk,
  input  logic                      rst,
  input  lsepc_pkg::stage_word_t    word,
  input  logic [7:0]                quot,
  output logic                      done,
  output logic [23:0]               pixel_color,
  output logic                      write_pixel
);

  logic [7:0]  pos_sum;
  logic [23:0] pixel_color_next;

  assign pos_sum = word.pos + quot;

  always_comb begin
    case (word.src)
      lsepc_pkg::SRC_WHEEL: pixel_color_next = lsepc_pkg::wheel(word.pos);
      lsepc_pkg::SRC_CYCLE: pixel_color_next = lsepc_pkg::wheel(pos_sum);
      default:              pixel_color_next = word.flat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= word.valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_color <= pixel_color_next;
    write_pixel <= word.wr;
  end

endmodule

@@ hdl/led_strip_effect_pixel_color_unit.sv @@
// top level of the led strip pixel colour unit
// One pixel request is taken every clock while busy is low; busy is high only
// during reset and the cycle after. The pipeline has three register stages:
// input decode with the first half of the strip-position divide, effect select
// with the second half of the divide, then the colour wheel and output register.
// A result appears with done high after the request has passed the stage one,
// stage two and output registers, for one cycle only, and the receiver cannot
// stall it. Registers are written through cfg_write, cfg_index and cfg_data
// and must only change while no request is in flight.
`include "led_strip_effect_pixel_color_unit_assert.svh"

module led_strip_effect_pixel_color_unit #(
  parameter int MAX_PIXELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [10:0] frame_step,
  input  logic [1:0]  chase_offset,
  input  logic        lit_pass,
  input  logic [3:0]  pixel_index,
  input  logic        glyph_bit,
  output logic        done,
  output logic [23:0] pixel_color,
  output logic        write_pixel,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int NCAP = (MAX_PIXELS > 31) ? 31 : MAX_PIXELS;
  localparam logic [4:0] N_CAP = 5'(NCAP);

  lsepc_pkg::effect_t effect;
  logic [4:0]         pixel_count;
  logic [23:0]        fore_color;
  logic [23:0]        back_color;

  logic [4:0] n_eff;
  logic       accept;

  logic        s1_valid;
  logic        s1_in_range;
  logic        s1_chase_hit;
  logic        s1_wipe_hit;
  logic        s1_lit;
  logic        s1_gbit;
  logic [7:0]  s1_step8;
  logic [7:0]  s1_rb_pos;
  logic [11:0] s1_crb_x;

  lsepc_pkg::stage_word_t s2_word;
  lsepc_pkg::stage_word_t s2_word_next;
  logic [7:0]             quot;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      effect      <= lsepc_pkg::EFF_RAINBOW;
      pixel_count <= lsepc_pkg::PIXEL_COUNT_RESET;
      fore_color  <= 24'd0;
      back_color  <= 24'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        lsepc_pkg::REG_EFFECT:      effect      <= lsepc_pkg::effect_t'(cfg_data[2:0]);
        lsepc_pkg::REG_PIXEL_COUNT: pixel_count <= cfg_data[4:0];
        lsepc_pkg::REG_FORE_COLOR:  fore_color  <= cfg_data;
        lsepc_pkg::REG_BACK_COLOR:  back_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;
  assign n_eff  = (pixel_count > N_CAP) ? N_CAP : pixel_count;

  // stage one: decode the word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_in_range  <= {1'b0, pixel_index} < n_eff;
    s1_chase_hit <= lsepc_pkg::mod3(pixel_index) == chase_offset;
    s1_wipe_hit  <= {7'd0, pixel_index} <= frame_step;
    s1_lit       <= lit_pass;
    s1_gbit      <= glyph_bit;
    s1_step8     <= frame_step[7:0];
    s1_rb_pos    <= frame_step[7:0] + {4'd0, pixel_index};
    s1_crb_x     <= {1'b0, frame_step} + {8'd0, pixel_index} - {10'd0, chase_offset};
  end

  lsepc_div u_div (
    .clk  (clk),
    .p    (pixel_index),
    .n    (n_eff),
    .quot (quot)
  );

  // stage two: effect select
  always_comb begin
    s2_word_next.valid = s1_valid;
    s2_word_next.wr    = 1'b0;
    s2_word_next.src   = lsepc_pkg::SRC_FLAT;
    s2_word_next.pos   = 8'd0;
    s2_word_next.flat  = 24'd0;
    if (s1_in_range) begin
      case (effect)
        lsepc_pkg::EFF_RAINBOW: begin
          s2_word_next.wr  = 1'b1;
          s2_word_next.src = lsepc_pkg::SRC_WHEEL;
          s2_word_next.pos = s1_rb_pos;
        end
        lsepc_pkg::EFF_CYCLE: begin
          s2_word_next.wr  = 1'b1;
          s2_word_next.src = lsepc_pkg::SRC_CYCLE;
          s2_word_next.pos = s1_step8;
        end
        lsepc_pkg::EFF_CHASE: begin
          if (s1_chase_hit) begin
            s2_word_next.wr   = 1'b1;
            s2_word_next.flat = s1_lit ? fore_color : 24'd0;
          end
        end
        lsepc_pkg::EFF_CHASE_RB: begin
          if (s1_chase_hit) begin
            s2_word_next.wr = 1'b1;
            if (s1_lit) begin
              s2_word_next.src = lsepc_pkg::SRC_WHEEL;
              s2_word_next.pos = lsepc_pkg::mod255(s1_crb_x);
            end
          end
        end
        lsepc_pkg::EFF_WIPE: begin
          if (s1_wipe_hit) begin
            s2_word_next.wr   = 1'b1;
            s2_word_next.flat = fore_color;
          end
        end
        lsepc_pkg::EFF_BLINK: begin
          s2_word_next.wr   = 1'b1;
          s2_word_next.flat = s1_lit ? fore_color : 24'd0;
        end
        lsepc_pkg::EFF_GLYPH: begin
          s2_word_next.wr   = 1'b1;
          s2_word_next.flat = s1_gbit ? fore_color : back_color;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_word <= '0;
    end else begin
      s2_word <= s2_word_next;
    end
  end

  // stage three: colour and output word
  lsepc_color u_color (
    .clk         (clk),
    .rst         (rst),
    .word        (s2_word),
    .quot        (quot),
    .done        (done),
    .pixel_color (pixel_color),
    .write_pixel (write_pixel)
  );

  `LSEPC_ASSERT_IMP(a_done_latency, done, $past(start && !busy, 3))
  `LSEPC_ASSERT_IMP(a_nowrite_black, done && !write_pixel, pixel_color == 24'd0)
  `LSEPC_ASSERT_IMP(a_busy_after_reset, !$past(rst), !busy)
  `LSEPC_ASSERT_NEXT(a_stage_to_done, s2_word.valid, done)

endmodule
